// ===== design/oahm_pkg.sv =====
// ----------------------------------------------------------------------------
// oahm_pkg
// Shared constants and types for the open addressing hash map core.
// ----------------------------------------------------------------------------
package oahm_pkg;

    localparam int CAPACITY   = 256;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int HASH_BITS  = 64;

    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int OCC_BITS   = 9;
    localparam int LIMIT_BITS = 9;
    localparam int OP_BITS    = 2;
    localparam int STAT_BITS  = 2;
    localparam int IDX_BITS   = 8;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;

    localparam int ENTRY_BITS = HASH_BITS + KEY_BITS + VALUE_BITS;

    localparam int IN_BITS    = OP_BITS + KEY_W + HASH_BITS + VAL_W;
    localparam int IN_TDATA   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = STAT_BITS + VAL_W + IDX_BITS;
    localparam int OUT_TDATA  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [LIMIT_BITS-1:0] LOAD_LIMIT_RESET = 9'd192;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_SPARE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SL_EMPTY = 2'd0,
        SL_FULL  = 2'd1,
        SL_TOMB  = 2'd2,
        SL_SPARE = 2'd3
    } t_slot;

    typedef enum logic [STAT_BITS-1:0] {
        RS_DONE  = 2'd0,
        RS_MISS  = 2'd1,
        RS_FULL  = 2'd2,
        RS_SPARE = 2'd3
    } t_res;

endpackage

// ===== design/open_addressing_hash_map_core.sv =====
// ----------------------------------------------------------------------------
// open_addressing_hash_map_core
// Linear probing key/value table with tombstones, held in block RAM.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                         Item
// s         in   i_s_tvalid/o_s_tready/i_s_tdata  op, key, key_hash, value
// m         out  o_m_tvalid/i_m_tready/o_m_tdata  status, found_value, slot_index
// cfg       in   i_cfg_valid/o_cfg_ready/i_cfg_data  load_limit
//
// Each slot visited takes a RAM read, then a compare; around that probe loop
// come an accept step, a write-back step and a hand-over step.
// The probe loop around the slot RAM read port sets the time per item.
// Reset is synchronous; per-slot valid flops clear the status store at once,
// so no clearing pass is needed. A result waiting in the output register does
// not block the next item; only a second finished result waits for it.
// A limit write is taken only when idle with the output register empty, and
// holds off the input while it is offered.
// ----------------------------------------------------------------------------
module open_addressing_hash_map_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // op[1:0], key[33:2], key_hash[97:34], value[129:98], zero pad
    input  logic [oahm_pkg::IN_TDATA-1:0]      i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // status[1:0], found_value[33:2], slot_index[41:34], zero pad
    output logic [oahm_pkg::OUT_TDATA-1:0]     o_m_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [oahm_pkg::LIMIT_BITS-1:0]    i_cfg_data
);

    localparam int AW = oahm_pkg::ADDR_BITS;
    localparam int CW = oahm_pkg::CNT_BITS;
    localparam int HB = oahm_pkg::HASH_BITS;
    localparam int KB = oahm_pkg::KEY_BITS;
    localparam int VB = oahm_pkg::VALUE_BITS;
    localparam logic [CW-1:0] CAP_CNT = CW'(oahm_pkg::CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_WR,
        S_DONE
    } t_state;

    t_state r_state;

    logic [oahm_pkg::OP_BITS-1:0]    r_op;
    logic [KB-1:0]                   r_key;
    logic [HB-1:0]                   r_hash;
    logic [VB-1:0]                   r_val;
    logic [AW-1:0]                   r_loc;
    logic [CW-1:0]                   r_cnt;
    logic                            r_have_tomb;
    logic [AW-1:0]                   r_tomb;
    logic                            r_found;
    logic                            r_placeable;
    logic                            r_place_empty;
    logic [AW-1:0]                   r_target;
    logic [VB-1:0]                   r_hit_val;
    logic [oahm_pkg::OCC_BITS-1:0]   r_occ;
    logic [oahm_pkg::LIMIT_BITS-1:0] r_limit;
    logic [oahm_pkg::CAPACITY-1:0]   r_vld;
    logic                            r_vld_q;

    logic                            r_out_valid;
    logic [oahm_pkg::STAT_BITS-1:0]  r_out_stat;
    logic [oahm_pkg::VAL_W-1:0]      r_out_val;
    logic [oahm_pkg::IDX_BITS-1:0]   r_out_idx;
    logic [oahm_pkg::STAT_BITS-1:0]  r_res_stat;
    logic [oahm_pkg::VAL_W-1:0]      r_res_val;
    logic [oahm_pkg::IDX_BITS-1:0]   r_res_idx;

    logic [1:0]                      st_rdata;
    logic [oahm_pkg::ENTRY_BITS-1:0] en_rdata;
    logic                            st_we;
    logic [1:0]                      st_wdata;
    logic                            en_we;
    logic [oahm_pkg::ENTRY_BITS-1:0] en_wdata;
    logic                            rd_en;

    logic [oahm_pkg::STAT_BITS-1:0]  wb_stat;
    logic [oahm_pkg::VAL_W-1:0]      wb_val;
    logic [oahm_pkg::IDX_BITS-1:0]   wb_idx;
    logic                            occ_inc;

    logic [1:0]                      cur_st;
    logic                            cur_match;
    logic [CW-1:0]                   cnt_nx;
    logic                            s_acc;
    logic                            cfg_acc;
    logic                            out_free;

    assign s_acc       = i_s_tvalid && o_s_tready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_out_valid;
    assign out_free    = !r_out_valid || i_m_tready;
    assign rd_en       = (r_state == S_RD);

    assign cur_st    = r_vld_q ? st_rdata : oahm_pkg::SL_EMPTY;
    assign cur_match = (en_rdata[HB-1:0] == r_hash) && (en_rdata[HB+KB-1:HB] == r_key);
    assign cnt_nx    = r_cnt + CW'(1);

    // write-back decision and result, made from the registered probe outcome
    always_comb begin
        st_we    = 1'b0;
        st_wdata = oahm_pkg::SL_FULL;
        en_we    = 1'b0;
        en_wdata = {r_val, r_key, r_hash};
        wb_stat  = oahm_pkg::RS_DONE;
        wb_val   = '0;
        wb_idx   = oahm_pkg::IDX_BITS'(r_target);
        occ_inc  = 1'b0;
        if (r_state == S_WR) begin
            case (r_op)
                oahm_pkg::OP_INSERT: begin
                    if (r_found) begin
                        en_we = 1'b1;
                    end else if (r_placeable && (r_occ < r_limit)) begin
                        en_we   = 1'b1;
                        st_we   = 1'b1;
                        occ_inc = r_place_empty;
                    end else begin
                        wb_stat = oahm_pkg::RS_FULL;
                        wb_idx  = '0;
                    end
                end
                oahm_pkg::OP_REMOVE: begin
                    if (r_found) begin
                        st_we    = 1'b1;
                        st_wdata = oahm_pkg::SL_TOMB;
                    end else begin
                        wb_stat = oahm_pkg::RS_MISS;
                        wb_idx  = '0;
                    end
                end
                default: begin
                    if (r_found) begin
                        wb_val = r_hit_val;
                    end else begin
                        wb_stat = oahm_pkg::RS_MISS;
                        wb_idx  = '0;
                    end
                end
            endcase
        end
    end

    oahm_ram #(.WIDTH(2), .DEPTH(oahm_pkg::CAPACITY)) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_target),
        .i_wdata (st_wdata),
        .i_re    (rd_en),
        .i_raddr (r_loc),
        .o_rdata (st_rdata)
    );

    oahm_ram #(.WIDTH(oahm_pkg::ENTRY_BITS), .DEPTH(oahm_pkg::CAPACITY)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (en_we),
        .i_waddr (r_target),
        .i_wdata (en_wdata),
        .i_re    (rd_en),
        .i_raddr (r_loc),
        .o_rdata (en_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_limit     <= oahm_pkg::LOAD_LIMIT_RESET;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_acc) begin
                r_limit <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_op        <= i_s_tdata[1:0];
                        r_key       <= i_s_tdata[KB+1:2];
                        r_hash      <= i_s_tdata[HB+33:34];
                        r_val       <= i_s_tdata[VB+97:98];
                        r_loc       <= i_s_tdata[AW+33:34];
                        r_cnt       <= '0;
                        r_have_tomb <= 1'b0;
                        r_state     <= S_RD;
                    end
                end
                S_RD: begin
                    r_vld_q <= r_vld[r_loc];
                    r_state <= S_EV;
                end
                S_EV: begin
                    if (cur_st == oahm_pkg::SL_EMPTY) begin
                        r_found       <= 1'b0;
                        r_placeable   <= 1'b1;
                        r_place_empty <= !r_have_tomb;
                        r_target      <= r_have_tomb ? r_tomb : r_loc;
                        r_state       <= S_WR;
                    end else if (cur_st == oahm_pkg::SL_FULL && cur_match) begin
                        r_found   <= 1'b1;
                        r_target  <= r_loc;
                        r_hit_val <= en_rdata[HB+KB+VB-1:HB+KB];
                        r_state   <= S_WR;
                    end else begin
                        if (cur_st == oahm_pkg::SL_TOMB && !r_have_tomb) begin
                            r_have_tomb <= 1'b1;
                            r_tomb      <= r_loc;
                        end
                        r_cnt <= cnt_nx;
                        r_loc <= r_loc + AW'(1);
                        if (cnt_nx == CAP_CNT) begin
                            // every slot seen, none empty, no match
                            r_found     <= 1'b0;
                            r_placeable <= 1'b0;
                            r_state     <= S_WR;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_WR: begin
                    r_res_stat <= wb_stat;
                    r_res_val  <= wb_val;
                    r_res_idx  <= wb_idx;
                    if (st_we) begin
                        r_vld[r_target] <= 1'b1;
                    end
                    if (occ_inc) begin
                        r_occ <= r_occ + oahm_pkg::OCC_BITS'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_stat <= r_res_stat;
                        r_out_val  <= r_res_val;
                        r_out_idx  <= r_res_idx;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(oahm_pkg::OUT_TDATA - oahm_pkg::OUT_BITS){1'b0}},
                         r_out_idx, r_out_val, r_out_stat};

    // occupancy only ever steps up by one, and only out of a write-back
    property p_occ_step;
        @(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_occ != $past(r_occ))) |-> ($past(r_state) == S_WR)
                                    && (r_occ == $past(r_occ) + oahm_pkg::OCC_BITS'(1));
    endproperty
    a_occ_step: assert property (p_occ_step) else $error("occupancy stepped wrongly");

    property p_occ_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= oahm_pkg::OCC_BITS'(oahm_pkg::CAPACITY);
    endproperty
    a_occ_bound: assert property (p_occ_bound) else $error("occupancy beyond capacity");

    property p_probe_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_EV) |-> (r_cnt < CAP_CNT);
    endproperty
    a_probe_bound: assert property (p_probe_bound) else $error("probe ran past capacity");

    property p_no_write_outside;
        @(posedge i_clk) disable iff (!i_rst_n)
        (st_we || en_we) |-> (r_state == S_WR);
    endproperty
    a_no_write_outside: assert property (p_no_write_outside) else $error("stray RAM write");

endmodule

// ===== design/oahm_ram.sv =====
// ----------------------------------------------------------------------------
// oahm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module oahm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sim/open_addressing_hash_map_core_tb.sv =====
// ----------------------------------------------------------------------------
// open_addressing_hash_map_core_tb
// Self-checking bench for the hash map core. Items are queued by an initial
// block and driven onto the input stream with random idle bursts. Every
// accepted item is run through a behavioural table model, and its result is
// queued. The output stream is stalled at random, and once for a long
// stretch. Each result is compared field by field against the oldest queued
// result. Phases: reset limit, limit zero, limit 256 filling every slot,
// limit 511 for probe wrap-around, then limit one with no idling.
// ----------------------------------------------------------------------------
module open_addressing_hash_map_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        oahm_pkg::t_op op;
        logic [31:0]   key;
        logic [63:0]   key_hash;
        logic [31:0]   value;
    } t_map_req;

    typedef struct packed {
        oahm_pkg::t_res status;
        logic [31:0]    found_value;
        logic [7:0]     slot_index;
    } t_map_res;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_s_tvalid = 1'b0;
    logic                              o_s_tready;
    logic [oahm_pkg::IN_TDATA-1:0]     i_s_tdata = '0;
    logic                              o_m_tvalid;
    logic                              i_m_tready = 1'b0;
    logic [oahm_pkg::OUT_TDATA-1:0]    o_m_tdata;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [oahm_pkg::LIMIT_BITS-1:0]   i_cfg_data = '0;

    open_addressing_hash_map_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // table model
    oahm_pkg::t_slot tbl_state [256];
    logic [63:0]     tbl_hash  [256];
    logic [31:0]     tbl_key   [256];
    logic [31:0]     tbl_value [256];
    logic [8:0]      occupancy = '0;
    logic [8:0]      load_limit = oahm_pkg::LOAD_LIMIT_RESET;

    t_map_req    pending [$];
    t_map_res    expected_res [$];
    int          n_pushed = 0;
    int          n_sent = 0;
    int          errors = 0;
    bit          calm = 1'b0;
    bit          hold_go = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_cnt = 0;

    logic [31:0] pool_key  [48];
    logic [63:0] pool_hash [48];
    logic [31:0] fill_key  [256];
    logic [63:0] fill_hash [256];
    logic [31:0] fill_rnd;

    initial begin
        for (int i = 0; i < 256; i++) tbl_state[i] = oahm_pkg::SL_EMPTY;
    end

    function automatic t_map_res apply_op(t_map_req r);
        logic [7:0] loc, tomb, hit, place;
        bit         have_tomb, found, placeable;
        t_map_res   res;
        loc = r.key_hash[7:0];
        tomb = '0; hit = '0; place = '0;
        have_tomb = 0; found = 0; placeable = 0;
        for (int n = 0; n < 256; n++) begin
            if (tbl_state[loc] == oahm_pkg::SL_EMPTY) begin
                place = have_tomb ? tomb : loc;
                placeable = 1;
                break;
            end
            if (tbl_state[loc] == oahm_pkg::SL_TOMB) begin
                if (!have_tomb) begin
                    have_tomb = 1;
                    tomb = loc;
                end
            end else if (tbl_hash[loc] == r.key_hash && tbl_key[loc] == r.key) begin
                hit = loc;
                found = 1;
                break;
            end
            loc = loc + 8'd1;
        end
        res = '{oahm_pkg::RS_MISS, 32'd0, 8'd0};
        case (r.op)
            oahm_pkg::OP_INSERT: begin
                if (found) begin
                    tbl_hash[hit] = r.key_hash;
                    tbl_key[hit] = r.key;
                    tbl_value[hit] = r.value;
                    res = '{oahm_pkg::RS_DONE, 32'd0, hit};
                end else if (!placeable || occupancy >= load_limit) begin
                    res.status = oahm_pkg::RS_FULL;
                end else begin
                    if (tbl_state[place] == oahm_pkg::SL_EMPTY) occupancy = occupancy + 9'd1;
                    tbl_state[place] = oahm_pkg::SL_FULL;
                    tbl_hash[place] = r.key_hash;
                    tbl_key[place] = r.key;
                    tbl_value[place] = r.value;
                    res = '{oahm_pkg::RS_DONE, 32'd0, place};
                end
            end
            oahm_pkg::OP_REMOVE: begin
                if (found) begin
                    tbl_state[hit] = oahm_pkg::SL_TOMB;
                    res = '{oahm_pkg::RS_DONE, 32'd0, hit};
                end
            end
            default: begin
                // spare op code behaves as a lookup
                if (found) res = '{oahm_pkg::RS_DONE, tbl_value[hit], hit};
            end
        endcase
        return res;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // input driver
    t_map_req tx_cur;
    int       tx_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_res.push_back(apply_op(tx_cur));
                n_sent++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (tx_gap > 0 && !calm) begin
                    tx_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pending.size() > 0) begin
                    tx_cur = pending.pop_front();
                    i_s_tdata <= {{(oahm_pkg::IN_TDATA-oahm_pkg::IN_BITS){1'b0}},
                                  tx_cur.value, tx_cur.key_hash, tx_cur.key, tx_cur.op};
                    i_s_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 4) == 0) tx_gap = $urandom_range(1, 10);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, so the core backs up and stalls its input
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_cnt <= 300;
            hold_done <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // output monitor
    int       rx_gap = 0;
    t_map_res got, want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = '{oahm_pkg::t_res'(o_m_tdata[1:0]), o_m_tdata[33:2], o_m_tdata[41:34]};
                if (expected_res.size() == 0) begin
                    report("unexpected result", o_m_tdata, 64'd0);
                end else begin
                    want = expected_res.pop_front();
                    if (got.status != want.status) report("status", got.status, want.status);
                    if (got.found_value != want.found_value)
                        report("found_value", got.found_value, want.found_value);
                    if (got.slot_index != want.slot_index)
                        report("slot_index", got.slot_index, want.slot_index);
                end
            end
            if (hold_cnt > 0) begin
                i_m_tready <= 1'b0;
            end else if (calm) begin
                i_m_tready <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if ($urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 10);
            end
        end
    end

    task automatic push_item(oahm_pkg::t_op op, logic [31:0] key, logic [63:0] hash,
                             logic [31:0] val);
        pending.push_back('{op, key, hash, val});
        n_pushed++;
    endtask

    task automatic drain();
        while (n_sent < n_pushed || expected_res.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [8:0] v);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        load_limit = v;
    endtask

    function automatic oahm_pkg::t_op pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return oahm_pkg::OP_INSERT;
        if (r < 75) return oahm_pkg::OP_LOOKUP;
        if (r < 95) return oahm_pkg::OP_REMOVE;
        return oahm_pkg::OP_SPARE;
    endfunction

    task automatic random_pool_items(int count, bit use_fill);
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 47);
            if ($urandom_range(0, 9) == 0)
                push_item(pick_op(), $urandom, {$urandom, $urandom}, $urandom);
            else if (use_fill && $urandom_range(0, 1))
                push_item(pick_op(), fill_key[k*5], fill_hash[k*5], $urandom);
            else
                push_item(pick_op(), pool_key[k], pool_hash[k], $urandom);
        end
    endtask

    initial begin
        #20_000_000;
        $display("open_addressing_hash_map_core_tb NOT OK");
        $finish;
    end

    initial begin
        for (int i = 0; i < 48; i++) begin
            pool_key[i] = $urandom;
            pool_hash[i] = {$urandom, $urandom};
            // cluster most home slots so probes run long and collide
            if (i < 36) pool_hash[i][7:0] = 8'($urandom_range(0, 15));
        end
        // same hash with another key, and same key with another hash
        pool_hash[1] = pool_hash[0];
        pool_key[3] = pool_key[2];
        pool_hash[3][7:0] = pool_hash[2][7:0];

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, collisions, updates, tombstones, wrap
        push_item(oahm_pkg::OP_INSERT, 32'h0, 64'h0, 32'h0);
        push_item(oahm_pkg::OP_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        push_item(oahm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        push_item(oahm_pkg::OP_INSERT, 32'h1, 64'h0, 32'h1111);
        push_item(oahm_pkg::OP_INSERT, 32'h0, 64'h8000_0000_0000_0000, 32'h2222);
        push_item(oahm_pkg::OP_LOOKUP, 32'h0, 64'h8000_0000_0000_0000, 32'h0);
        push_item(oahm_pkg::OP_LOOKUP, 32'h1, 64'h0, 32'h0);
        push_item(oahm_pkg::OP_INSERT, 32'h0, 64'h0, 32'hA5A5_5A5A);
        push_item(oahm_pkg::OP_LOOKUP, 32'h0, 64'h0, 32'h0);
        push_item(oahm_pkg::OP_REMOVE, 32'h1, 64'h0, 32'hFFFF_FFFF);
        push_item(oahm_pkg::OP_REMOVE, 32'h1, 64'h0, 32'h0);
        push_item(oahm_pkg::OP_LOOKUP, 32'h0, 64'h8000_0000_0000_0000, 32'h0);
        push_item(oahm_pkg::OP_INSERT, 32'h7, 64'h0000_0000_0000_0100, 32'h7777);
        push_item(oahm_pkg::OP_SPARE, 32'h7, 64'h0000_0000_0000_0100, 32'h0);
        push_item(oahm_pkg::OP_LOOKUP, 32'h1234_5678, 64'h0, 32'h0);
        push_item(oahm_pkg::OP_REMOVE, 32'h1234_5678, 64'h0, 32'h0);
        push_item(oahm_pkg::OP_INSERT, 32'h5, 64'h0000_0000_0000_00FF, 32'h5555);
        push_item(oahm_pkg::OP_LOOKUP, 32'h5, 64'h0000_0000_0000_00FF, 32'h0);
        push_item(oahm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0);
        hold_go = 1'b1;
        random_pool_items(80, 0);
        drain();

        // limit zero: new keys refused, updates still go through
        write_limit(9'd0);
        random_pool_items(20, 0);
        drain();

        // limit 256: fill every slot
        write_limit(9'd256);
        for (int i = 0; i < 256; i++) begin
            fill_key[i] = $urandom;
            fill_rnd = $urandom;
            fill_hash[i] = {$urandom, fill_rnd[23:0], i[7:0]};
            push_item(oahm_pkg::OP_INSERT, fill_key[i], fill_hash[i], $urandom);
        end
        drain();

        // above capacity: a new key is refused only once the probe wraps
        write_limit(9'd511);
        push_item(oahm_pkg::OP_INSERT, $urandom, {$urandom, $urandom}, $urandom);
        push_item(oahm_pkg::OP_LOOKUP, $urandom, {$urandom, $urandom}, 32'h0);
        random_pool_items(30, 1);
        drain();

        calm = 1'b1;
        write_limit(9'd1);
        random_pool_items(20, 1);
        drain();

        if (errors == 0 && expected_res.size() == 0) begin
            $display("open_addressing_hash_map_core_tb OK");
        end else begin
            $display("open_addressing_hash_map_core_tb NOT OK");
        end
        $finish;
    end

endmodule
